@@ rtl/core/waypoint_path_densifier_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the waypoint path densifier.
// Shorthand for clocked concurrent assertions that are disabled during reset.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_PATH_DENSIFIER_ASSERT_SVH
`define WAYPOINT_PATH_DENSIFIER_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define WPD_ASSERT_NOW(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The antecedent at one edge implies the consequent at the next edge.
`define WPD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/wpd_pkg.sv @@
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared constants, codes and control types of the waypoint path densifier.
// ----------------------------------------------------------------------------
package wpd_pkg;

   // Default segment point cap and coordinate fraction width.
   localparam int MAX_SEGMENT_POINTS = 62;
   localparam int COORD_FRAC_BITS    = 16;

   // Reset value of the points per metre register.
   localparam logic [7:0] PPM_RESET = 8'd20;

   // Last counter values of the square root and divider iterations, and the counter width.
   localparam int STEP_CNT_W = 6;
   localparam logic [STEP_CNT_W-1:0] SQRT_LAST = 6'd31;
   localparam logic [STEP_CNT_W-1:0] DIV_LAST  = 6'd32;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF,
      OP_SQUARE,
      OP_SUM,
      OP_SQRT,
      OP_SCALE,
      OP_COUNT,
      OP_DIV,
      OP_STEP,
      OP_STORE,
      OP_CLEAR
   } op_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_DIFF,
      ST_SQUARE,
      ST_SUM,
      ST_SQRT,
      ST_SCALE,
      ST_COUNT,
      ST_DIV,
      ST_EMIT,
      ST_FINAL,
      ST_STORE
   } state_type;

   // Command from controller to datapath.
   typedef struct packed {
      op_type op;
      logic   show_final;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic have_prev;
      logic path_end;
      logic seg_last;
   } status_type;

endpackage

@@ rtl/core/wpd_if.sv @@
// ----------------------------------------------------------------------------
// wpd_if
// Handshake channels of the densifier: waypoints in, points out, register write.
// ----------------------------------------------------------------------------
interface wpd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic               path_end;

   modport source (output valid, output pos_x, output pos_y, output path_end,
                   input ready);
   modport sink (input valid, input pos_x, input pos_y, input path_end,
                 output ready);
endinterface

interface wpd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic [15:0]        seq_index;
   logic               run_last;
   logic               final_point;
   logic               clipped;

   modport source (output valid, output out_x, output out_y, output seq_index,
                   output run_last, output final_point, output clipped,
                   input ready);
   modport sink (input valid, input out_x, input out_y, input seq_index,
                 input run_last, input final_point, input clipped,
                 output ready);
endinterface

interface wpd_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/wpd_controller.sv @@
// ----------------------------------------------------------------------------
// wpd_controller
// Sequencer of the densifier: steps each waypoint through the datapath.
// ----------------------------------------------------------------------------
module wpd_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wpd_pkg::status_type status,
   output wpd_pkg::cmd_type    cmd
);

   wpd_pkg::state_type state_ff, state_in;
   logic [wpd_pkg::STEP_CNT_W-1:0] cnt_ff, cnt_in;

   // State and iteration counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wpd_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // The counter runs only in the iterative states.
   always_comb begin
      if (state_ff == wpd_pkg::ST_SQRT || state_ff == wpd_pkg::ST_DIV) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = '0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wpd_pkg::ST_IDLE: begin
            if (req_valid) state_in = wpd_pkg::ST_ROUTE;
         end
         wpd_pkg::ST_ROUTE: begin
            if (status.have_prev)     state_in = wpd_pkg::ST_DIFF;
            else if (status.path_end) state_in = wpd_pkg::ST_FINAL;
            else                      state_in = wpd_pkg::ST_STORE;
         end
         wpd_pkg::ST_DIFF:   state_in = wpd_pkg::ST_SQUARE;
         wpd_pkg::ST_SQUARE: state_in = wpd_pkg::ST_SUM;
         wpd_pkg::ST_SUM:    state_in = wpd_pkg::ST_SQRT;
         wpd_pkg::ST_SQRT: begin
            if (cnt_ff == wpd_pkg::SQRT_LAST) state_in = wpd_pkg::ST_SCALE;
         end
         wpd_pkg::ST_SCALE:  state_in = wpd_pkg::ST_COUNT;
         wpd_pkg::ST_COUNT:  state_in = wpd_pkg::ST_DIV;
         wpd_pkg::ST_DIV: begin
            if (cnt_ff == wpd_pkg::DIV_LAST) state_in = wpd_pkg::ST_EMIT;
         end
         wpd_pkg::ST_EMIT: begin
            if (rsp_ready && status.seg_last) begin
               state_in = status.path_end ? wpd_pkg::ST_FINAL : wpd_pkg::ST_STORE;
            end
         end
         wpd_pkg::ST_FINAL: begin
            if (rsp_ready) state_in = wpd_pkg::ST_IDLE;
         end
         wpd_pkg::ST_STORE:  state_in = wpd_pkg::ST_IDLE;
         default:            state_in = wpd_pkg::ST_IDLE;
      endcase
   end

   // Outputs: handshakes and the datapath command.
   always_comb begin
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd.op         = wpd_pkg::OP_NONE;
      cmd.show_final = 1'b0;
      case (state_ff)
         wpd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = wpd_pkg::OP_LOAD;
         end
         wpd_pkg::ST_ROUTE:  cmd.op = wpd_pkg::OP_NONE;
         wpd_pkg::ST_DIFF:   cmd.op = wpd_pkg::OP_DIFF;
         wpd_pkg::ST_SQUARE: cmd.op = wpd_pkg::OP_SQUARE;
         wpd_pkg::ST_SUM:    cmd.op = wpd_pkg::OP_SUM;
         wpd_pkg::ST_SQRT:   cmd.op = wpd_pkg::OP_SQRT;
         wpd_pkg::ST_SCALE:  cmd.op = wpd_pkg::OP_SCALE;
         wpd_pkg::ST_COUNT:  cmd.op = wpd_pkg::OP_COUNT;
         wpd_pkg::ST_DIV:    cmd.op = wpd_pkg::OP_DIV;
         wpd_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) cmd.op = wpd_pkg::OP_STEP;
         end
         wpd_pkg::ST_FINAL: begin
            rsp_valid      = 1'b1;
            cmd.show_final = 1'b1;
            if (rsp_ready) cmd.op = wpd_pkg::OP_CLEAR;
         end
         wpd_pkg::ST_STORE:  cmd.op = wpd_pkg::OP_STORE;
         default:            cmd.op = wpd_pkg::OP_NONE;
      endcase
   end

endmodule

@@ rtl/core/wpd_datapath.sv @@
// ----------------------------------------------------------------------------
// wpd_datapath
// Segment arithmetic of the densifier: length, point count and interpolation.
// ----------------------------------------------------------------------------
module wpd_datapath #(
   parameter int MAX_PTS   = wpd_pkg::MAX_SEGMENT_POINTS,
   parameter int FRAC_BITS = wpd_pkg::COORD_FRAC_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  wpd_pkg::cmd_type    cmd,
   output wpd_pkg::status_type status,
   input  logic signed [31:0]  pos_x,
   input  logic signed [31:0]  pos_y,
   input  logic                path_end,
   input  logic                csr_write,
   input  logic [7:0]          csr_data,
   output logic signed [31:0]  out_x,
   output logic signed [31:0]  out_y,
   output logic [15:0]         seq_index,
   output logic                run_last,
   output logic                final_point,
   output logic                clipped
);

   localparam int NW = $clog2(MAX_PTS + 1);

   // Control state.
   logic [7:0]  ppm_ff;
   logic        have_ff;
   logic [15:0] seq_ff;
   // Waypoints and segment payload.
   logic [31:0] prevx_ff, prevy_ff, p2x_ff, p2y_ff;
   logic        end_ff, clip_ff, negx_ff, negy_ff, huge_ff;
   logic [32:0] ax_ff, ay_ff;
   logic [61:0] sqx_ff, sqy_ff;
   logic [63:0] rad_ff;
   logic [34:0] srem_ff;
   logic [31:0] root_ff;
   logic [39:0] prod_ff;
   logic [NW-1:0] n_ff, k_ff;
   logic [32:0] dvx_ff, dvy_ff;
   logic [NW-1:0] dvrx_ff, dvry_ff, rx_ff, ry_ff;
   logic [31:0] qx_ff, qy_ff;

   // Segment differences and magnitudes.
   logic [32:0] dx, dy, adx, ady;
   always_comb begin
      dx  = {p2x_ff[31], p2x_ff} - {prevx_ff[31], prevx_ff};
      dy  = {p2y_ff[31], p2y_ff} - {prevy_ff[31], prevy_ff};
      adx = dx[32] ? (33'd0 - dx) : dx;
      ady = dy[32] ? (33'd0 - dy) : dy;
   end

   // One digit pair of the square root.
   logic [34:0] remsh, trial;
   logic        root_ge;
   always_comb begin
      remsh   = {srem_ff[32:0], rad_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      root_ge = remsh >= trial;
   end

   // Point count from the scaled length, saturated at the cap; zero when points per metre is zero.
   logic [39:0]   nraw;
   logic [NW-1:0] n_new;
   logic          clip_new;
   always_comb begin
      nraw     = prod_ff >> FRAC_BITS;
      n_new    = nraw[NW-1:0];
      clip_new = 1'b0;
      if (ppm_ff == 8'd0) begin
         n_new = '0;
      end else if (huge_ff || nraw > 40'(MAX_PTS)) begin
         n_new    = NW'(MAX_PTS);
         clip_new = 1'b1;
      end
   end

   // One quotient bit of each restoring divider.
   logic [NW:0]   tx, ty;
   logic          gex, gey;
   always_comb begin
      tx  = {dvrx_ff, dvx_ff[32]};
      ty  = {dvry_ff, dvy_ff[32]};
      gex = tx >= {1'b0, n_ff};
      gey = ty >= {1'b0, n_ff};
   end

   // Running quotient and remainder of j * |d| / n.
   logic [NW:0] sx, sy;
   logic        wrapx, wrapy;
   always_comb begin
      sx    = {1'b0, rx_ff} + {1'b0, dvrx_ff};
      sy    = {1'b0, ry_ff} + {1'b0, dvry_ff};
      wrapx = sx >= {1'b0, n_ff};
      wrapy = sy >= {1'b0, n_ff};
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ppm_ff  <= wpd_pkg::PPM_RESET;
         have_ff <= 1'b0;
         seq_ff  <= '0;
      end else begin
         if (csr_write) ppm_ff <= csr_data;
         case (cmd.op)
            wpd_pkg::OP_STEP:  seq_ff <= seq_ff + 16'd1;
            wpd_pkg::OP_STORE: have_ff <= 1'b1;
            wpd_pkg::OP_CLEAR: begin
               have_ff <= 1'b0;
               seq_ff  <= '0;
            end
            default: ;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         wpd_pkg::OP_LOAD: begin
            p2x_ff  <= pos_x;
            p2y_ff  <= pos_y;
            end_ff  <= path_end;
            clip_ff <= 1'b0;
         end
         wpd_pkg::OP_DIFF: begin
            ax_ff   <= adx;
            ay_ff   <= ady;
            negx_ff <= dx[32];
            negy_ff <= dy[32];
            huge_ff <= adx[32] | adx[31] | ady[32] | ady[31];
         end
         wpd_pkg::OP_SQUARE: begin
            sqx_ff <= ax_ff[30:0] * ax_ff[30:0];
            sqy_ff <= ay_ff[30:0] * ay_ff[30:0];
         end
         wpd_pkg::OP_SUM: begin
            rad_ff  <= {1'b0, {1'b0, sqx_ff} + {1'b0, sqy_ff}};
            srem_ff <= '0;
            root_ff <= '0;
         end
         wpd_pkg::OP_SQRT: begin
            rad_ff  <= {rad_ff[61:0], 2'b00};
            srem_ff <= root_ge ? (remsh - trial) : remsh;
            root_ff <= {root_ff[30:0], root_ge};
         end
         wpd_pkg::OP_SCALE: prod_ff <= {8'd0, root_ff} * {32'd0, ppm_ff};
         wpd_pkg::OP_COUNT: begin
            n_ff    <= n_new;
            clip_ff <= clip_new;
            k_ff    <= '0;
            dvx_ff  <= ax_ff;
            dvy_ff  <= ay_ff;
            dvrx_ff <= '0;
            dvry_ff <= '0;
            rx_ff   <= '0;
            ry_ff   <= '0;
            qx_ff   <= '0;
            qy_ff   <= '0;
         end
         wpd_pkg::OP_DIV: begin
            dvrx_ff <= gex ? NW'(tx - {1'b0, n_ff}) : tx[NW-1:0];
            dvry_ff <= gey ? NW'(ty - {1'b0, n_ff}) : ty[NW-1:0];
            dvx_ff  <= {dvx_ff[31:0], gex};
            dvy_ff  <= {dvy_ff[31:0], gey};
         end
         wpd_pkg::OP_STEP: begin
            // The first two points both sit on p1, so accumulation starts late.
            k_ff <= k_ff + 1'b1;
            if (k_ff != '0) begin
               rx_ff <= wrapx ? NW'(sx - {1'b0, n_ff}) : sx[NW-1:0];
               ry_ff <= wrapy ? NW'(sy - {1'b0, n_ff}) : sy[NW-1:0];
               qx_ff <= qx_ff + dvx_ff[31:0] + {31'd0, wrapx};
               qy_ff <= qy_ff + dvy_ff[31:0] + {31'd0, wrapy};
            end
         end
         wpd_pkg::OP_STORE: begin
            prevx_ff <= p2x_ff;
            prevy_ff <= p2y_ff;
         end
         wpd_pkg::OP_CLEAR: begin
            prevx_ff <= '0;
            prevy_ff <= '0;
         end
         default: ;
      endcase
   end

   // Index of the last point of the segment.
   logic [NW-1:0] last_k;
   assign last_k = (n_ff > NW'(2)) ? (n_ff - NW'(2)) : '0;

   assign status.have_prev = have_ff;
   assign status.path_end  = end_ff;
   assign status.seg_last  = (k_ff == last_k);

   // Output point: p1 plus the signed offset, or the final waypoint.
   logic [31:0] offx, offy;
   always_comb begin
      offx = negx_ff ? (32'd0 - qx_ff) : qx_ff;
      offy = negy_ff ? (32'd0 - qy_ff) : qy_ff;
   end

   assign out_x       = cmd.show_final ? signed'(p2x_ff) : signed'(prevx_ff + offx);
   assign out_y       = cmd.show_final ? signed'(p2y_ff) : signed'(prevy_ff + offy);
   assign seq_index   = seq_ff;
   assign run_last    = cmd.show_final | (status.seg_last & ~end_ff);
   assign final_point = cmd.show_final;
   assign clipped     = clip_ff;

endmodule

@@ rtl/core/waypoint_path_densifier.sv @@
// ----------------------------------------------------------------------------
// waypoint_path_densifier
// Turns a stream of 2D waypoints into a densely interpolated path.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one waypoint item (pos_x, pos_y, path_end) at a time;
//   req_chan.ready is high only while no waypoint is in work.
//   rsp_chan gives the emitted points, one item per cycle while the receiver
//   takes them; a stall simply holds the current item on the channel.
//   csr_chan writes points_per_meter; it is always ready.
//   For a waypoint with a predecessor the segment arithmetic after acceptance
//   (chiefly a 32-step square root and a 33-step divider) comes first, then n-1
//   points (at least one) follow one per cycle while the receiver takes them,
//   plus the final point when path_end is set. A first waypoint gives only
//   its final point, and only when path_end is set.
//   Reset clears the previous waypoint, the sequence number and the
//   register (points_per_meter back to 20); no item is pending after it.
// ----------------------------------------------------------------------------
module waypoint_path_densifier #(
   parameter int MAX_PTS   = wpd_pkg::MAX_SEGMENT_POINTS,
   parameter int FRAC_BITS = wpd_pkg::COORD_FRAC_BITS
) (
   input  logic       clock,
   input  logic       reset,
   wpd_req_if.sink    req_chan,
   wpd_rsp_if.source  rsp_chan,
   wpd_csr_if.sink    csr_chan
);

   wpd_pkg::cmd_type    cmd;
   wpd_pkg::status_type status;

   // The register port never stalls.
   assign csr_chan.ready = 1'b1;

   wpd_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   wpd_datapath #(
      .MAX_PTS   (MAX_PTS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .pos_x       (req_chan.pos_x),
      .pos_y       (req_chan.pos_y),
      .path_end    (req_chan.path_end),
      .csr_write   (csr_chan.valid),
      .csr_data    (csr_chan.data),
      .out_x       (rsp_chan.out_x),
      .out_y       (rsp_chan.out_y),
      .seq_index   (rsp_chan.seq_index),
      .run_last    (rsp_chan.run_last),
      .final_point (rsp_chan.final_point),
      .clipped     (rsp_chan.clipped)
   );

endmodule

@@ rtl/core/wpd_checker.sv @@
// ----------------------------------------------------------------------------
// wpd_checker
// Port-level checks of the densifier, bound to the top level.
// ----------------------------------------------------------------------------
`include "waypoint_path_densifier_assert.svh"

module wpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_out_x,
   input logic [15:0] rsp_seq_index,
   input logic        rsp_run_last,
   input logic        rsp_final_point
);

   // A stalled item holds.
   `WPD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_x) && $stable(rsp_seq_index), "stalled item changed")

   // No waypoint is taken while points are still being delivered.
   `WPD_ASSERT_NOW(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "input taken during output")

   // The final point always closes its run.
   `WPD_ASSERT_NOW(a_final_last, clock, reset, !(rsp_valid && rsp_final_point) || rsp_run_last, "final point not last")

   // Within a run the next item follows at once with the next sequence number.
   `WPD_ASSERT_NEXT(a_seq_next, clock, reset, rsp_valid && rsp_ready && !rsp_run_last, rsp_valid && (rsp_seq_index == $past(rsp_seq_index) + 16'd1), "sequence gap in run")

endmodule

bind waypoint_path_densifier wpd_checker u_wpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_out_x       (rsp_chan.out_x),
   .rsp_seq_index   (rsp_chan.seq_index),
   .rsp_run_last    (rsp_chan.run_last),
   .rsp_final_point (rsp_chan.final_point)
);

@@ tb/sv/wpd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wpd_tb_checker
// Watches the densifier channels, predicts the emitted points of every
// accepted waypoint item and compares each accepted point item field by field.
// ----------------------------------------------------------------------------
module wpd_tb_checker (
   input  logic      clock,
   input  logic      reset,
   wpd_req_if.sink   req_mon,
   wpd_rsp_if.sink   rsp_mon,
   wpd_csr_if.sink   csr_mon,
   output int        fail_count,
   output int        pending_count,
   output int        point_count,
   output int        clip_count
);

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic [15:0]        seq;
      logic               last;
      logic               fin;
      logic               clip;
   } point_type;

   point_type         expected_points[$];
   logic [7:0]        ppm;
   logic signed [31:0] last_x, last_y;
   logic              held;
   logic [15:0]       next_seq;

   // Bitwise integer square root of a 64 bit value.
   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v   = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   task automatic push_point(longint px, longint py, logic fin, logic clip);
      point_type p;
      p.x    = px[31:0];
      p.y    = py[31:0];
      p.seq  = next_seq;
      p.last = 1'b0;
      p.fin  = fin;
      p.clip = clip;
      expected_points = {expected_points, p};
      next_seq = next_seq + 16'd1;
   endtask

   // Works out the points caused by one waypoint item.
   task automatic densify(logic signed [31:0] x2, logic signed [31:0] y2, logic is_end);
      longint dx, dy, nn, j;
      longint unsigned ax, ay, n;
      logic clip;
      int before_len;
      clip = 1'b0;
      before_len = expected_points.size();
      if (held) begin
         dx = longint'(x2) - longint'(last_x);
         dy = longint'(y2) - longint'(last_y);
         ax = dx < 0 ? -dx : dx;
         ay = dy < 0 ? -dy : dy;
         if (ppm == 0) n = 0;
         else if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
            n = wpd_pkg::MAX_SEGMENT_POINTS + 1;
         else n = (root64(ax * ax + ay * ay) * ppm) >> wpd_pkg::COORD_FRAC_BITS;
         if (n > wpd_pkg::MAX_SEGMENT_POINTS) begin
            n = wpd_pkg::MAX_SEGMENT_POINTS;
            clip = 1'b1;
         end
         push_point(last_x, last_y, 1'b0, clip);
         if (n > 2) begin
            nn = n;
            for (j = 0; j < nn - 2; j++)
               push_point(longint'(last_x) + (j * dx) / nn,
                          longint'(last_y) + (j * dy) / nn, 1'b0, clip);
         end
      end
      if (is_end) begin
         push_point(x2, y2, 1'b1, clip);
         last_x = 0; last_y = 0; held = 1'b0; next_seq = 0;
      end else begin
         last_x = x2; last_y = y2; held = 1'b1;
      end
      if (expected_points.size() > before_len)
         expected_points[expected_points.size()-1].last = 1'b1;
   endtask

   task automatic report(string what, longint got, longint want);
      $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   assign pending_count = expected_points.size();

   // Predict on accepted waypoints and register writes; check accepted points.
   always @(posedge clock) begin
      point_type e;
      if (reset) begin
         ppm = wpd_pkg::PPM_RESET; held = 0; last_x = 0; last_y = 0; next_seq = 0;
         expected_points.delete();
         fail_count = 0; point_count = 0; clip_count = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) ppm = csr_mon.data;
         if (req_mon.valid && req_mon.ready)
            densify(req_mon.pos_x, req_mon.pos_y, req_mon.path_end);
         if (rsp_mon.valid && rsp_mon.ready) begin
            point_count++;
            if (rsp_mon.clipped) clip_count++;
            if (expected_points.size() == 0) begin
               report("unexpected point item seq_index", rsp_mon.seq_index, 0);
            end else begin
               e = expected_points.pop_front();
               if (rsp_mon.out_x !== e.x) report("out_x", rsp_mon.out_x, e.x);
               if (rsp_mon.out_y !== e.y) report("out_y", rsp_mon.out_y, e.y);
               if (rsp_mon.seq_index !== e.seq) report("seq_index", rsp_mon.seq_index, e.seq);
               if (rsp_mon.run_last !== e.last) report("run_last", rsp_mon.run_last, e.last);
               if (rsp_mon.final_point !== e.fin)
                  report("final_point", rsp_mon.final_point, e.fin);
               if (rsp_mon.clipped !== e.clip) report("clipped", rsp_mon.clipped, e.clip);
            end
         end
      end
   end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives waypoint items and register writes into the densifier with random
// gaps and stalls, and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
   logic clock, reset;
   int   fails, pending, points, clips;
   int   hold_off;
   int   waypoints;

   wpd_req_if req_chan();
   wpd_rsp_if rsp_chan();
   wpd_csr_if csr_chan();

   waypoint_path_densifier uut (.clock(clock), .reset(reset), .req_chan(req_chan),
                                .rsp_chan(rsp_chan), .csr_chan(csr_chan));

   wpd_tb_checker chk (.clock(clock), .reset(reset), .req_mon(req_chan), .rsp_mon(rsp_chan),
                       .csr_mon(csr_chan), .fail_count(fails), .pending_count(pending),
                       .point_count(points), .clip_count(clips));

   // Clock generation.
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: random stalls, or a long hold-off when asked.
   initial begin
      int w;
      rsp_chan.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_off > 0) begin
            rsp_chan.ready <= 0;
            hold_off--;
         end else if (rsp_chan.ready && !rsp_chan.valid) begin
            // Keep ready up while nothing is offered.
         end else begin
            w = $urandom_range(0, 3);
            if (rsp_chan.ready && rsp_chan.valid && w > 0) begin
               rsp_chan.ready <= 0;
               repeat (w - 1) @(posedge clock);
               @(posedge clock);
               rsp_chan.ready <= 1;
            end else begin
               rsp_chan.ready <= 1;
            end
         end
      end
   end

   // Offers one waypoint item and waits until it is accepted. Valid stays up
   // after acceptance; the block is never ready in the following cycle, and the
   // next item or an explicit drop of valid replaces it.
   task automatic send_waypoint(logic [31:0] x, logic [31:0] y, logic e);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1;
      req_chan.pos_x    <= x;
      req_chan.pos_y    <= y;
      req_chan.path_end <= e;
      do @(posedge clock); while (!req_chan.ready);
      waypoints++;
   endtask

   // Waits for all points to drain and the block to settle, then writes the register.
   task automatic write_ppm(logic [7:0] v);
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      csr_chan.valid <= 1;
      csr_chan.data  <= v;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 0;
   endtask

   // Random coordinate near a base point, mostly short segments.
   function automatic logic [31:0] near(logic [31:0] b);
      return b + 32'($signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000);
   endfunction

   // Watchdog.
   initial begin
      #20ms;
      $display("timeout");
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [31:0] bx, by;
      int i, k, len;
      hold_off = 0; waypoints = 0;
      reset = 1;
      req_chan.valid = 0; req_chan.pos_x = 0; req_chan.pos_y = 0; req_chan.path_end = 0;
      csr_chan.valid = 0; csr_chan.data = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: first point alone, short and long segments, extremes.
      send_waypoint(32'h0001_0000, 32'h0002_0000, 1);
      send_waypoint(0, 0, 0);
      send_waypoint(32'h0000_8000, 0, 0);
      send_waypoint(32'h0002_0000, 32'hFFFF_0000, 0);
      send_waypoint(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
      send_waypoint(32'h8000_0000, 32'h8000_0000, 0);
      send_waypoint(32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_waypoint(32'h8000_1000, 32'h7FFF_0000, 0);
      send_waypoint(32'hFFFF_FFFF, 32'h0000_0001, 1);
      send_waypoint(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      write_ppm(8'd255);
      send_waypoint(0, 0, 0);
      send_waypoint(32'h0000_0100, 32'hFFFF_FF00, 0);
      send_waypoint(32'h0000_2000, 32'h0000_1000, 1);
      write_ppm(8'd0);
      send_waypoint(0, 0, 0);
      send_waypoint(32'h0100_0000, 32'h0100_0000, 1);
      write_ppm(8'd1);
      send_waypoint(0, 0, 0);
      send_waypoint(32'h0028_0000, 32'hFFE0_0000, 0);
      send_waypoint(32'h5555_5555, 32'hAAAA_AAAA, 1);

      // Long receiver hold-off while waypoints keep coming.
      write_ppm(8'd20);
      hold_off = 300;
      for (i = 0; i < 4; i++) send_waypoint(i * 32'h0002_8000, 32'h0001_0000, i == 3);

      // Random paths under several register settings.
      for (k = 0; k < 8; k++) begin
         case (k)
            0: write_ppm(8'd1);
            1: write_ppm(8'd255);
            2: write_ppm(8'd0);
            default: write_ppm(8'($urandom_range(1, 255)));
         endcase
         for (i = 0; i < 45; i += len) begin
            len = $urandom_range(1, 8);
            bx = $urandom_range(0, 7) == 0 ? $urandom : $urandom & 32'h8003_FFFF;
            by = $urandom_range(0, 7) == 0 ? $urandom : $urandom & 32'h8003_FFFF;
            for (int j = 0; j < len; j++) begin
               if ($urandom_range(0, 15) == 0) begin
                  bx = $urandom; by = $urandom;
               end else begin
                  bx = near(bx); by = near(by);
               end
               send_waypoint(bx, by, (j == len - 1) && ($urandom_range(0, 5) != 0));
            end
         end
      end

      // Drain and settle.
      req_chan.valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d waypoint items and checked %0d point items (%0d clipped).",
               waypoints, points, clips);
      $display("Register settings covered 0, 1, 20, 255 and random values.");
      if (fails == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
